[rtl/iirdf1c_pkg.sv]
// ----------------------------------------------------------------------------
// Clamped direct form I IIR filter: shared definitions
// Widths, register indexes and the structures that pass between modules.
// ----------------------------------------------------------------------------
package iirdf1c_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned FracW   = 28;
  localparam int unsigned ProdW   = SampleW + CoefW;
  localparam int unsigned AccW    = ProdW + 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  typedef enum logic [2:0] {
    RegB0,
    RegB1,
    RegB2,
    RegA1,
    RegA2,
    RegOutMin,
    RegOutMax
  } reg_idx_e;

  typedef struct packed {
    coef_t   b0;
    coef_t   b1;
    coef_t   b2;
    coef_t   a1;
    coef_t   a2;
    sample_t out_min;
    sample_t out_max;
  } cfg_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  localparam coef_t   B0Reset     = 32'sh1000_0000;
  localparam sample_t OutMinReset = 32'sh8000_0000;
  localparam sample_t OutMaxReset = 32'sh7fff_ffff;

endpackage

[rtl/iirdf1c_in_if.sv]
// ----------------------------------------------------------------------------
// Input sample channel
// Valid/ready channel that carries one sample and its restart flag.
// ----------------------------------------------------------------------------
interface iirdf1c_in_if import iirdf1c_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);

endinterface

[rtl/iirdf1c_out_if.sv]
// ----------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel that carries one filtered sample and its limit flag.
// ----------------------------------------------------------------------------
interface iirdf1c_out_if import iirdf1c_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    limited;

  modport source (output valid, output filtered, output limited, input ready);
  modport sink   (input valid, input filtered, input limited, output ready);

endinterface

[rtl/iirdf1c_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the coefficients and the output limits.
// ----------------------------------------------------------------------------
module iirdf1c_regs import iirdf1c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0      <= B0Reset;
      cfg_q.b1      <= '0;
      cfg_q.b2      <= '0;
      cfg_q.a1      <= '0;
      cfg_q.a2      <= '0;
      cfg_q.out_min <= OutMinReset;
      cfg_q.out_max <= OutMaxReset;
    end else if (wr_en) begin
      case (idx)
        RegB0:     cfg_q.b0      <= coef_t'(pwdata);
        RegB1:     cfg_q.b1      <= coef_t'(pwdata);
        RegB2:     cfg_q.b2      <= coef_t'(pwdata);
        RegA1:     cfg_q.a1      <= coef_t'(pwdata);
        RegA2:     cfg_q.a2      <= coef_t'(pwdata);
        RegOutMin: cfg_q.out_min <= sample_t'(pwdata);
        RegOutMax: cfg_q.out_max <= sample_t'(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegB0:     prdata = DataW'(cfg_q.b0);
      RegB1:     prdata = DataW'(cfg_q.b1);
      RegB2:     prdata = DataW'(cfg_q.b2);
      RegA1:     prdata = DataW'(cfg_q.a1);
      RegA2:     prdata = DataW'(cfg_q.a2);
      RegOutMin: prdata = DataW'(cfg_q.out_min);
      RegOutMax: prdata = DataW'(cfg_q.out_max);
      default:   prdata = '0;
    endcase
  end

endmodule

[rtl/iirdf1c_calc.sv]
// ----------------------------------------------------------------------------
// Filter arithmetic
// Up to five products, exact sum, rounding, saturation and min/max clamp.
// ----------------------------------------------------------------------------
module iirdf1c_calc import iirdf1c_pkg::*; #(
  parameter int unsigned TAPS         = 3,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  sample_t x_i,
  input  logic    init_i,
  input  hist_t   hist_i,
  input  cfg_t    cfg_i,
  output hist_t   hist_o,
  output sample_t y_o,
  output logic    limited_o
);

  localparam int unsigned ShW  = AccW - FracW;
  localparam int unsigned SatW = (SAMPLE_WIDTH < SampleW) ? SAMPLE_WIDTH : SampleW;
  localparam logic signed [ShW-1:0]  LimHi     = (ShW'(1) << (SatW - 1)) - ShW'(1);
  localparam logic signed [ShW-1:0]  LimLo     = ~LimHi;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) << (FracW - 1);

  coef_t   b0, b1, b2, a1, a2;
  sample_t x, x1, x2, y1, y2;
  sample_t out_min, out_max;

  logic signed [ProdW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AccW-1:0]  acc;
  logic signed [ShW-1:0]   v;
  logic signed [ShW-1:0]   sat;
  sample_t                 sat_s;
  sample_t                 y_hi;
  sample_t                 y;

  assign b0      = cfg_i.b0;
  assign b1      = cfg_i.b1;
  assign b2      = cfg_i.b2;
  assign a1      = cfg_i.a1;
  assign a2      = cfg_i.a2;
  assign out_min = cfg_i.out_min;
  assign out_max = cfg_i.out_max;

  // A restart or the first sample fills the input history with the sample
  // and clears the output history.
  assign x  = x_i;
  assign x1 = init_i ? x_i : hist_i.x1;
  assign x2 = init_i ? x_i : hist_i.x2;
  assign y1 = init_i ? '0  : hist_i.y1;
  assign y2 = init_i ? '0  : hist_i.y2;

  assign p_b0 = b0 * x;

  if (TAPS > 1) begin : g_tap1
    assign p_b1 = b1 * x1;
    assign p_a1 = a1 * y1;
  end else begin : g_no_tap1
    assign p_b1 = '0;
    assign p_a1 = '0;
  end

  if (TAPS > 2) begin : g_tap2
    assign p_b2 = b2 * x2;
    assign p_a2 = a2 * y2;
  end else begin : g_no_tap2
    assign p_b2 = '0;
    assign p_a2 = '0;
  end

  assign acc = AccW'(p_b0) + AccW'(p_b1) + AccW'(p_b2)
             - AccW'(p_a1) - AccW'(p_a2) + RoundHalf;
  assign v   = acc[AccW-1:FracW];

  always_comb begin
    if (v > LimHi) begin
      sat = LimHi;
    end else if (v < LimLo) begin
      sat = LimLo;
    end else begin
      sat = v;
    end
  end

  assign sat_s = sat[SampleW-1:0];
  assign y_hi  = (sat_s > out_max) ? out_max : sat_s;
  assign y     = (y_hi < out_min) ? out_min : y_hi;

  assign y_o       = y;
  assign limited_o = (sat != v) || (y != sat_s);

  assign hist_o.x1 = x;
  assign hist_o.x2 = x1;
  assign hist_o.y1 = y;
  assign hist_o.y2 = y1;

endmodule

[rtl/iir_filter_direct_form_one_clamped.sv]
// ----------------------------------------------------------------------------
// Clamped direct form I IIR filter
// Second-order fixed-point IIR filter with saturation and output clamping.
// ----------------------------------------------------------------------------
// Samples arrive on in_i (sample in Q16.16, restart flag) and leave on out_o
// (filtered sample in Q16.16, limited flag), both valid/ready channels; one
// result is produced for every input transfer. Coefficients (Q4.28) and the
// output limits are written through the APB-style port; the user must write
// them only while the filter is idle; the block itself does not enforce it.
// An accepted sample is held in the input register, then the whole filter
// step is evaluated combinationally and lands in the output register when
// that register is empty or the receiver takes its current result.
// One sample per cycle is sustained while out_o.ready stays high; the output
// history feeds back through the combinational step, which sets the rate.
// Reset loads the default coefficients (unity gain), opens the limits fully
// and clears the histories; the first sample after reset fills the input
// history with itself. When the receiver stalls, the output register holds
// its result; one further sample is taken into the input register only if
// that register is empty, and then in_i.ready drops.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one_clamped import iirdf1c_pkg::*; #(
  parameter int unsigned TAPS         = 3,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  iirdf1c_in_if.sink       in_i,
  iirdf1c_out_if.source    out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  hist_t   hist_q, hist_d;
  logic    primed_q;
  logic    in_vld_q;
  sample_t x_q;
  logic    restart_q;
  logic    out_vld_q;
  sample_t y_q;
  logic    lim_q;
  sample_t y_d;
  logic    lim_d;
  logic    advance;
  logic    in_take;

  iirdf1c_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iirdf1c_calc #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_calc (
    .x_i       (x_q),
    .init_i    (restart_q || !primed_q),
    .hist_i    (hist_q),
    .cfg_i     (cfg),
    .hist_o    (hist_d),
    .y_o       (y_d),
    .limited_o (lim_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = y_q;
  assign out_o.limited  = lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      primed_q  <= 1'b0;
      hist_q    <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        primed_q  <= 1'b1;
        hist_q    <= hist_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q       <= in_i.sample;
      restart_q <= in_i.restart;
    end
    if (advance) begin
      y_q   <= y_d;
      lim_q <= lim_d;
    end
  end

endmodule
